@@ src/cftp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cftp_pkg: types and constants of the CAN frame text parser
// Lexer phases, result status codes, channel words and the parser context.
// ----------------------------------------------------------------------------
package cftp_pkg;

    typedef enum logic [3:0] {
        PH_IDLE = 4'd0,
        PH_ZERO = 4'd1,
        PH_HEX0 = 4'd2,
        PH_HEX  = 4'd3,
        PH_OCT  = 4'd4,
        PH_BIN0 = 4'd5,
        PH_BIN  = 4'd6,
        PH_DEC  = 4'd7,
        PH_STOP = 4'd8
    } t_phase;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NO_ID     = 3'd1,
        ST_ID_BIG    = 3'd2,
        ST_TOO_MANY  = 3'd3,
        ST_BYTE_BIG  = 3'd4
    } t_status;

    localparam logic [31:0] ID_MAX      = 32'h0000_07ff;
    localparam logic [31:0] BYTE_MAX    = 32'h0000_00ff;
    localparam logic [31:0] DEC_LIMIT   = 32'd429496729;
    localparam logic [3:0]  BYTES_MAX   = 4'd8;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_1     = 8'h31;
    localparam logic [7:0] CH_5     = 8'h35;
    localparam logic [7:0] CH_7     = 8'h37;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UB    = 8'h42;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LB    = 8'h62;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_LX    = 8'h78;

    typedef struct packed {
        logic [7:0] ch;
        logic       end_of_line;
    } t_in_word;

    typedef struct packed {
        t_status     status;
        logic [10:0] frame_id;
        logic [3:0]  byte_count;
        logic [63:0] payload;
    } t_out_word;

    typedef struct packed {
        t_phase      phase;
        logic [31:0] acc;
        logic [3:0]  idx;
        logic [10:0] id;
        logic        seen;
        logic [63:0] bytes;
        t_status     status;
    } t_ctx;

    localparam t_ctx CTX_RESET = '{
        phase:  PH_IDLE,
        acc:    32'd0,
        idx:    4'd0,
        id:     11'd0,
        seen:   1'b0,
        bytes:  64'd0,
        status: ST_OK
    };

endpackage

@@ src/can_frame_text_parser_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// can_frame_text_parser_top: command line to CAN frame parser
// Lexes one character per word into an 11-bit ID and up to eight data bytes
// and reports the frame with a status when the end-of-line word is taken.
// ----------------------------------------------------------------------------
// The result word is registered and valid in the cycle after its end-of-line word is taken.
// Throughput: one character word per cycle unless stalled; the character path is a
//   single register stage holding the lexer context, the result sits in its own
//   output register so input is taken in the same cycle a waiting result is read.
// Input stalls only while a result is held and the sink is not ready.
// Reset (i_rst_n low, synchronous) clears the lexer context and the result valid flag.
module can_frame_text_parser_top
    import cftp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_data
);

    t_ctx      r_ctx;
    t_ctx      n_ctx;
    logic      r_out_valid;
    t_out_word r_out_data;
    t_out_word n_out_data;
    logic      w_accept;

    // ------------------------------------------------------------------
    // Context helpers
    // ------------------------------------------------------------------
    function automatic t_ctx f_commit(input t_ctx s, input logic [31:0] n);
        t_ctx r;
        r = s;
        r.phase = PH_IDLE;
        if (!s.seen) begin
            if (n > ID_MAX) begin
                r.status = ST_ID_BIG;
                r.phase  = PH_STOP;
            end else begin
                r.id   = n[10:0];
                r.seen = 1'b1;
            end
        end else if (s.idx >= BYTES_MAX) begin
            r.status = ST_TOO_MANY;
            r.phase  = PH_STOP;
        end else if (n > BYTE_MAX) begin
            r.status = ST_BYTE_BIG;
            r.phase  = PH_STOP;
        end else begin
            for (int k = 0; k < 8; k++) begin
                if (s.idx[2:0] == k[2:0]) begin
                    r.bytes[8*k +: 8] = s.bytes[8*k +: 8] | n[7:0];
                end
            end
            r.idx = s.idx + 4'd1;
        end
        return r;
    endfunction

    function automatic t_ctx f_start(input t_ctx s, input logic [7:0] c);
        t_ctx r;
        r = s;
        if (c > CH_SPACE) begin
            if (c == CH_0) begin
                r.phase = PH_ZERO;
                r.acc   = 32'd0;
            end else if (c >= CH_1 && c <= CH_9) begin
                r.phase = PH_DEC;
                r.acc   = {28'd0, c[3:0]};
            end else if (c == CH_LB || c == CH_UB) begin
                r.phase = PH_BIN0;
                r.acc   = 32'd0;
            end else begin
                r.phase = PH_STOP;
            end
        end
        return r;
    endfunction

    // end the number on c, then let c start the next token
    function automatic t_ctx f_restart(input t_ctx s, input logic [7:0] c,
                                       input logic [31:0] n);
        t_ctx r;
        r = f_commit(s, n);
        if (r.phase == PH_IDLE) begin
            r = f_start(r, c);
        end
        return r;
    endfunction

    // {valid, digit}
    function automatic logic [4:0] f_hex(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= CH_0 && c <= CH_9) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= CH_UA && c <= CH_UF) || (c >= CH_LA && c <= CH_LF)) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

    function automatic t_ctx f_finish(input t_ctx s);
        t_ctx r;
        r = s;
        case (s.phase)
            PH_ZERO: r = f_commit(s, 32'd0);
            PH_HEX, PH_OCT, PH_BIN, PH_DEC: r = f_commit(s, s.acc);
            default: r = s;
        endcase
        r.phase = PH_STOP;
        return r;
    endfunction

    function automatic t_ctx f_lex(input t_ctx s, input logic [7:0] c);
        t_ctx        r;
        logic [4:0]  hx;
        logic [31:0] dec_next;
        r        = s;
        hx       = f_hex(c);
        dec_next = (s.acc << 3) + (s.acc << 1) + {28'd0, c[3:0]};
        unique case (s.phase)
            PH_IDLE: r = f_start(s, c);
            PH_ZERO: begin
                if (c == CH_LX || c == CH_UX) begin
                    r.phase = PH_HEX0;
                end else if (c >= CH_0 && c <= CH_7) begin
                    r.phase = PH_OCT;
                    r.acc   = {29'd0, c[2:0]};
                end else begin
                    r = f_restart(s, c, 32'd0);
                end
            end
            PH_HEX0: begin
                if (!hx[4]) begin
                    r.phase = PH_STOP;
                end else begin
                    r.phase = PH_HEX;
                    r.acc   = {28'd0, hx[3:0]};
                end
            end
            PH_HEX: begin
                if (!hx[4]) begin
                    r = f_restart(s, c, s.acc);
                end else if (s.acc[31:28] != 4'd0) begin
                    r.phase = PH_STOP;
                end else begin
                    r.acc = {s.acc[27:0], hx[3:0]};
                end
            end
            PH_OCT: begin
                if (c < CH_0 || c > CH_7) begin
                    r = f_restart(s, c, s.acc);
                end else if (s.acc[31:29] != 3'd0) begin
                    r.phase = PH_STOP;
                end else begin
                    r.acc = {s.acc[28:0], c[2:0]};
                end
            end
            PH_BIN0: begin
                if (c == CH_0 || c == CH_1) begin
                    r.phase = PH_BIN;
                    r.acc   = {31'd0, c[0]};
                end else begin
                    r.phase = PH_STOP;
                end
            end
            PH_BIN: begin
                if (c != CH_0 && c != CH_1) begin
                    r = f_restart(s, c, s.acc);
                end else if (s.acc[31]) begin
                    r.phase = PH_STOP;
                end else begin
                    r.acc = {s.acc[30:0], c[0]};
                end
            end
            PH_DEC: begin
                if (c < CH_0 || c > CH_9) begin
                    r = f_restart(s, c, s.acc);
                end else if (s.acc > DEC_LIMIT || (s.acc == DEC_LIMIT && c > CH_5)) begin
                    r.phase = PH_STOP;
                end else begin
                    r.acc = dec_next;
                end
            end
            default: r.phase = PH_STOP;
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Per-character step
    // ------------------------------------------------------------------
    always_comb begin
        t_ctx s;
        t_ctx f;
        s = r_ctx;
        if (s.phase != PH_STOP) begin
            if (i_in_data.ch == CH_NUL) begin
                s = f_finish(s);
            end else begin
                s = f_lex(s, i_in_data.ch);
            end
        end
        f = f_finish(s);

        if (f.status != ST_OK) begin
            n_out_data.status = f.status;
        end else if (!f.seen) begin
            n_out_data.status = ST_NO_ID;
        end else begin
            n_out_data.status = ST_OK;
        end
        n_out_data.frame_id   = f.id;
        n_out_data.byte_count = f.idx;
        n_out_data.payload    = f.bytes;

        // start the next line from reset state
        n_ctx = i_in_data.end_of_line ? CTX_RESET : s;
    end

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctx       <= CTX_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_ctx <= n_ctx;
            end
            if (w_accept && i_in_data.end_of_line) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && i_in_data.end_of_line) begin
            r_out_data <= n_out_data;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_eol_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in_data.end_of_line) |=> o_out_valid)
        else $error("no result after end-of-line word");

    a_eol_clears_ctx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in_data.end_of_line) |=> (r_ctx.phase == PH_IDLE && !r_ctx.seen
            && r_ctx.idx == 4'd0 && r_ctx.bytes == 64'd0))
        else $error("lexer context not cleared after line");

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ctx.idx <= BYTES_MAX)
        else $error("byte index past eight");

    a_bytes_need_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ctx.idx != 4'd0) |-> r_ctx.seen)
        else $error("data byte taken before ID");

    a_ok_has_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status == ST_NO_ID) |-> (o_out_data.byte_count == 4'd0))
        else $error("bytes reported without ID");

endmodule

@@ tb/sv/can_frame_text_parser_top_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// can_frame_text_parser_top_test: self-checking bench for the frame parser
// Feeds command lines one character word at a time: a directed set of short
// lines for the corner cases, then random lines in every radix plus noise.
// A behavioral parser predicts each frame, and every result word is checked
// field by field in order. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module can_frame_text_parser_top_test;
    import cftp_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int CHAR_TARGET = 1550;
    localparam string NOISE_SET = "0123456789xXbBaAfFgz \t";

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_word  i_in_data;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_word o_out_data;

    can_frame_text_parser_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_in_word   pending[$];
    logic [7:0] line_buf[$];
    t_out_word  frames_due[$];
    t_out_word  frame_want;
    t_ctx       lex = CTX_RESET;

    int cycle_count = 0;
    int error_count = 0;
    int chars_total = 0;
    int chars_taken = 0;
    int line_count = 0;
    int frames_checked = 0;
    int status_seen[8];
    int in_gap = 0;
    int in_calm = 0;
    int out_hold = 0;
    int out_calm = 0;

    // ------------------------------------------------------------------
    // Parser prediction
    // ------------------------------------------------------------------
    function automatic int hex_digit(logic [7:0] c);
        if (c >= CH_0 && c <= CH_9) return int'(c - CH_0);
        if (c >= CH_UA && c <= CH_UF) return int'(c - CH_UA) + 10;
        if (c >= CH_LA && c <= CH_LF) return int'(c - CH_LA) + 10;
        return -1;
    endfunction

    function automatic void take_number(logic [31:0] n);
        lex.phase = PH_IDLE;
        if (!lex.seen) begin
            if (n > ID_MAX) begin
                lex.status = ST_ID_BIG;
                lex.phase  = PH_STOP;
            end else begin
                lex.id   = n[10:0];
                lex.seen = 1'b1;
            end
        end else if (lex.idx >= BYTES_MAX) begin
            lex.status = ST_TOO_MANY;
            lex.phase  = PH_STOP;
        end else if (n > BYTE_MAX) begin
            lex.status = ST_BYTE_BIG;
            lex.phase  = PH_STOP;
        end else begin
            lex.bytes[8 * lex.idx[2:0] +: 8] = n[7:0];
            lex.idx = lex.idx + 4'd1;
        end
    endfunction

    function automatic void open_token(logic [7:0] c);
        if (c > CH_SPACE) begin
            if (c == CH_0) begin
                lex.phase = PH_ZERO;
                lex.acc   = 32'd0;
            end else if (c >= CH_1 && c <= CH_9) begin
                lex.phase = PH_DEC;
                lex.acc   = 32'(c - CH_0);
            end else if (c == CH_LB || c == CH_UB) begin
                lex.phase = PH_BIN0;
                lex.acc   = 32'd0;
            end else begin
                lex.phase = PH_STOP;
            end
        end
    endfunction

    // The terminating character starts the next token unless the number stopped the line.
    function automatic void close_and_reopen(logic [7:0] c, logic [31:0] n);
        take_number(n);
        if (lex.phase == PH_IDLE) open_token(c);
    endfunction

    function automatic void advance_lexer(logic [7:0] c);
        int d;
        d = hex_digit(c);
        case (lex.phase)
            PH_IDLE: open_token(c);
            PH_ZERO: begin
                if (c == CH_LX || c == CH_UX) begin
                    lex.phase = PH_HEX0;
                end else if (c >= CH_0 && c <= CH_7) begin
                    lex.phase = PH_OCT;
                    lex.acc   = 32'(c - CH_0);
                end else begin
                    close_and_reopen(c, 32'd0);
                end
            end
            PH_HEX0: begin
                if (d < 0) begin
                    lex.phase = PH_STOP;
                end else begin
                    lex.phase = PH_HEX;
                    lex.acc   = d;
                end
            end
            PH_HEX: begin
                if (d < 0) close_and_reopen(c, lex.acc);
                else if (lex.acc[31:28] != 4'd0) lex.phase = PH_STOP;
                else lex.acc = {lex.acc[27:0], d[3:0]};
            end
            PH_OCT: begin
                if (c < CH_0 || c > CH_7) close_and_reopen(c, lex.acc);
                else if (lex.acc[31:29] != 3'd0) lex.phase = PH_STOP;
                else lex.acc = {lex.acc[28:0], c[2:0]};
            end
            PH_BIN0: begin
                if (c == CH_0 || c == CH_1) begin
                    lex.phase = PH_BIN;
                    lex.acc   = {31'd0, c[0]};
                end else begin
                    lex.phase = PH_STOP;
                end
            end
            PH_BIN: begin
                if (c != CH_0 && c != CH_1) close_and_reopen(c, lex.acc);
                else if (lex.acc[31]) lex.phase = PH_STOP;
                else lex.acc = {lex.acc[30:0], c[0]};
            end
            PH_DEC: begin
                if (c < CH_0 || c > CH_9) close_and_reopen(c, lex.acc);
                else if (lex.acc > DEC_LIMIT || (lex.acc == DEC_LIMIT && c > CH_5))
                    lex.phase = PH_STOP;
                else lex.acc = lex.acc * 10 + (c - CH_0);
            end
            default: lex.phase = PH_STOP;
        endcase
    endfunction

    // Complete a pending number as if the text ended here, then stop.
    function automatic void flush_token();
        case (lex.phase)
            PH_ZERO: take_number(32'd0);
            PH_HEX, PH_OCT, PH_BIN, PH_DEC: take_number(lex.acc);
            default: ;
        endcase
        lex.phase = PH_STOP;
    endfunction

    function automatic void parse_char(t_in_word w);
        t_out_word f;
        if (lex.phase != PH_STOP) begin
            if (w.ch == CH_NUL) flush_token();
            else advance_lexer(w.ch);
        end
        if (w.end_of_line) begin
            flush_token();
            if (lex.status != ST_OK) f.status = lex.status;
            else if (!lex.seen) f.status = ST_NO_ID;
            else f.status = ST_OK;
            f.frame_id   = lex.id;
            f.byte_count = lex.idx;
            f.payload    = lex.bytes;
            frames_due.push_back(f);
            lex = CTX_RESET;
        end
    endfunction

    // ------------------------------------------------------------------
    // Line building
    // ------------------------------------------------------------------
    function automatic logic [7:0] noise_char();
        if ($urandom_range(0, 99) < 40) return 8'($urandom_range(0, 255));
        return NOISE_SET[$urandom_range(0, NOISE_SET.len() - 1)];
    endfunction

    task automatic put_text(string s, bit upper);
        logic [7:0] c;
        for (int i = 0; i < s.len(); i++) begin
            c = s[i];
            if (upper && c >= CH_LA && c <= CH_LF) c = c - 8'h20;
            line_buf.push_back(c);
        end
    endtask

    task automatic put_gap(int min_len);
        int n;
        n = $urandom_range(min_len, min_len + 2);
        repeat (n) begin
            if ($urandom_range(0, 3) != 0) line_buf.push_back(CH_SPACE);
            else line_buf.push_back(8'($urandom_range(1, 32)));
        end
    endtask

    task automatic put_number(logic [31:0] v);
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) begin
            put_text($sformatf("%0d", v), 1'b0);
        end else if (r < 65) begin
            if ($urandom_range(0, 1)) put_text("0x", 1'b0);
            else put_text("0X", 1'b0);
            if ($urandom_range(0, 7) == 0) put_text("0", 1'b0);
            put_text($sformatf("%0h", v), 1'($urandom_range(0, 1)));
        end else if (r < 80) begin
            put_text($sformatf("0%0o", v), 1'b0);
        end else if (r < 95) begin
            if ($urandom_range(0, 1)) put_text("b", 1'b0);
            else put_text("B", 1'b0);
            put_text($sformatf("%0b", v), 1'b0);
        end else if (r < 98) begin
            // ten digits, always past 32 bits
            put_text($sformatf("%0d%0d", $urandom_range(42949673, 99999999),
                               $urandom_range(10, 99)), 1'b0);
        end else begin
            put_text($sformatf("0x%0h%08h", $urandom_range(1, 15), $urandom()), 1'b0);
        end
    endtask

    // Move the line into the pending queue, flagging its last character.
    task automatic close_line();
        t_in_word w;
        while (line_buf.size() != 0) begin
            w.ch = line_buf.pop_front();
            w.end_of_line = (line_buf.size() == 0);
            pending.push_back(w);
        end
        line_count++;
    endtask

    task automatic build_random_line();
        int kind, r, n;
        logic [31:0] v;
        kind = $urandom_range(0, 99);
        if (kind < 12) begin
            n = $urandom_range(1, 12);
            repeat (n) line_buf.push_back(noise_char());
        end else begin
            if ($urandom_range(0, 3) == 0) put_gap(0);
            r = $urandom_range(0, 99);
            if (r < 5) v = ID_MAX;
            else if (r < 8) v = 32'd0;
            else if (r < 90) v = $urandom_range(0, 2047);
            else if (r < 95) v = $urandom_range(2048, 70000);
            else v = $urandom();
            put_number(v);
            n = ($urandom_range(0, 9) != 0) ? $urandom_range(0, 8) : $urandom_range(9, 10);
            repeat (n) begin
                // occasionally run tokens together
                put_gap(($urandom_range(0, 19) == 0) ? 0 : 1);
                r = $urandom_range(0, 99);
                if (r < 5) v = BYTE_MAX;
                else if (r < 8) v = 32'd0;
                else if (r < 93) v = $urandom_range(0, 255);
                else if (r < 97) v = $urandom_range(256, 70000);
                else v = $urandom();
                put_number(v);
            end
            r = $urandom_range(0, 99);
            if (r < 10) begin
                line_buf.push_back(CH_NUL);
                n = $urandom_range(0, 4);
                repeat (n) line_buf.push_back(noise_char());
            end else if (r < 30) begin
                put_gap(1);
            end
            if (kind < 22) line_buf[$urandom_range(0, line_buf.size() - 1)] = noise_char();
        end
        close_line();
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want_v);
        error_count++;
        if (error_count <= 40)
            $display("mismatch at cycle %0d: %s got %0h expected %0h",
                     cycle_count, what, got, want_v);
    endtask

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("can_frame_text_parser_top_test: FAIL");
            $finish;
        end
    end

    // Input side: predict the frame for every accepted word.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            lex = CTX_RESET;
        end else if (i_in_valid && o_in_ready) begin
            parse_char(i_in_data);
            chars_taken++;
        end
    end

    // Output side: compare each accepted result word with the oldest frame.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (frames_due.size() == 0) begin
                report_mismatch("result with none expected, payload", o_out_data.payload,
                                64'd0);
            end else begin
                frame_want = frames_due.pop_front();
                if (o_out_data.status !== frame_want.status)
                    report_mismatch("status", 64'(o_out_data.status),
                                    64'(frame_want.status));
                if (o_out_data.frame_id !== frame_want.frame_id)
                    report_mismatch("frame_id", 64'(o_out_data.frame_id),
                                    64'(frame_want.frame_id));
                if (o_out_data.byte_count !== frame_want.byte_count)
                    report_mismatch("byte_count", 64'(o_out_data.byte_count),
                                    64'(frame_want.byte_count));
                if (o_out_data.payload !== frame_want.payload)
                    report_mismatch("payload", o_out_data.payload, frame_want.payload);
                frames_checked++;
                status_seen[frame_want.status]++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Handshake drivers
    // ------------------------------------------------------------------
    function automatic int pick_gap(inout int calm_left);
        int r;
        r = $urandom_range(0, 99);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if (r < 3) begin
            calm_left = $urandom_range(20, 80);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || o_in_ready) begin
            if (in_gap > 0) begin
                in_gap--;
                i_in_valid <= 1'b0;
            end else if (pending.size() != 0) begin
                i_in_data  <= pending.pop_front();
                i_in_valid <= 1'b1;
                in_gap = pick_gap(in_calm);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (out_hold > 0) begin
            out_hold--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            out_hold = pick_gap(out_calm);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_out_ready = 1'b0;

        put_text("2047 255 0 1", 1'b0);                   close_line();
        put_text("0X7fF 0xff 0377 b11111111 B0 00 9", 1'b0); close_line();
        put_text("2048", 1'b0);                           close_line();
        put_text("1 2 3 4 5 6 7 8 9 10", 1'b0);           close_line();
        put_text("5 256", 1'b0);                          close_line();
        put_text(" ", 1'b0);                              close_line();
        put_text("7 q1", 1'b0);                           close_line();
        put_text("3 0x", 1'b0);                           close_line();
        put_text("3 b2 4", 1'b0);                         close_line();
        put_text("0b1", 1'b0);                            close_line();
        put_text("4294967295", 1'b0);                     close_line();
        put_text("1 4294967296", 1'b0);                   close_line();
        put_text("1 0x100000000", 1'b0);                  close_line();
        put_text("1 040000000000", 1'b0);                 close_line();
        put_text("1 b1", 1'b0);
        put_text($sformatf("%032b", 32'd0), 1'b0);        close_line();
        put_text("6 7", 1'b0);
        line_buf.push_back(CH_NUL);
        put_text("8 9", 1'b0);                            close_line();
        put_text("12", 1'b0);
        line_buf.push_back(CH_NUL);                       close_line();
        line_buf.push_back(8'hff);                        close_line();
        put_text("1", 1'b0);
        line_buf.push_back(8'h80);
        put_text("2", 1'b0);                              close_line();

        while (pending.size() < CHAR_TARGET) build_random_line();
        chars_total = pending.size();

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (chars_taken < chars_total) @(negedge i_clk);
        while (frames_due.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        if (frames_due.size() != 0)
            report_mismatch("frames never delivered", 64'(frames_due.size()), 64'd0);

        $display("parsed %0d characters in %0d lines, %0d frames checked",
                 chars_taken, line_count, frames_checked);
        $display("frames: ok %0d, no id %0d, id too big %0d, too many %0d, byte too big %0d",
                 status_seen[ST_OK], status_seen[ST_NO_ID], status_seen[ST_ID_BIG],
                 status_seen[ST_TOO_MANY], status_seen[ST_BYTE_BIG]);
        if (error_count == 0) begin
            $display("can_frame_text_parser_top_test: PASS");
        end else begin
            $display("can_frame_text_parser_top_test: FAIL");
        end
        $finish;
    end

endmodule
